### rtl/bce_pkg.sv
package bce_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 5;

    localparam int COORD_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int T_W       = 16;
    localparam int NB_W      = 31;
    localparam int NB_FRAC   = 30;
    localparam int MAT_FRAC  = 12;
    localparam int DEN_W     = 8;
    localparam int DIV_STEP  = 4;
    localparam int CP_W      = NB_W + 1 + COORD_W;
    localparam int ACC_W     = 52;
    localparam int PX_W      = ACC_W - NB_FRAC;
    localparam int MP_W      = COORD_W + PX_W;
    localparam int MS_W      = MP_W + 1;
    localparam int MR_W      = MS_W - MAT_FRAC;
    localparam int MT_W      = MR_W + 1;

    localparam logic [2:0]         DEGREE_RST = 3'd3;
    localparam logic [7:0]         SCOUNT_RST = 8'd50;
    localparam logic [COORD_W-1:0] UNITY_Q12  = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGREE       = 3'd0,
        CFG_SAMPLE_COUNT = 3'd1,
        CFG_MAT_XX       = 3'd2,
        CFG_MAT_XY       = 3'd3,
        CFG_MAT_YX       = 3'd4,
        CFG_MAT_YY       = 3'd5,
        CFG_SHIFT_X      = 3'd6,
        CFG_SHIFT_Y      = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FEW_POINTS = 2'd1,
        STATUS_RANGE      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_DIV,
        ST_T_WAIT,
        ST_U_MUL,
        ST_SPAN,
        ST_B_PROD,
        ST_B_DIV,
        ST_B_WAIT,
        ST_S_RD,
        ST_S_MUL,
        ST_S_ACC,
        ST_X_RND,
        ST_X_MUL,
        ST_X_SUM,
        ST_DONE
    } bce_state_t;

    typedef struct packed {
        logic                       action;
        logic [5:0]                 point_index;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic                       last_point;
        logic [7:0]                 sample_index;
    } bce_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  curve_x;
        logic signed [COORD_W-1:0]  curve_y;
        status_t                    status;
    } bce_out_t;

endpackage

### rtl/bce_div.sv
module bce_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 8,
    parameter int STEP  = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int ITER  = (NUM_W + STEP - 1) / STEP;
    localparam int PAD_W = ITER * STEP;
    localparam int CNT_W = $clog2(ITER + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PAD_W-1:0] shf_reg, shf_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;

    // restoring division, STEP quotient bits per cycle
    always_comb begin
        logic [DEN_W:0] part;
        rem_next = rem_reg;
        shf_next = shf_reg;
        for (int i = 0; i < STEP; i++) begin
            part     = {rem_next, shf_next[PAD_W-1]};
            shf_next = {shf_next[PAD_W-2:0], 1'b0};
            if (part >= {1'b0, den_reg}) begin
                rem_next    = DEN_W'(part - {1'b0, den_reg});
                shf_next[0] = 1'b1;
            end else begin
                rem_next = part[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shf_reg <= PAD_W'(num);
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            shf_reg <= shf_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = shf_reg[NUM_W-1:0];

endmodule

### rtl/bspline_curve_evaluator_unit.sv
// Clamped uniform B-spline evaluator. A load request writes one control point into the point
// memory; with last_point set it also fixes the point count. An evaluate request returns one
// transformed, saturated point, worked out with the shared radix-16 divider: first the
// parameter division (skipped when sample_count is zero), then two divisions for each of the
// d(d+1)/2 Cox-de Boor terms whose knot span is not empty, then the control points are read and
// weighted, and last comes the transform. The divider is 38 bits wide at 64 points. Requests
// with too few points or an out-of-range sample answer without evaluating. One request is
// worked at a time.
module bspline_curve_evaluator_unit
    import bce_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bce_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bce_out_t             m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int DW    = $clog2(MAX_DEGREE + 1);
    localparam int KIW   = $clog2(MAX_POINTS + 2 * MAX_DEGREE + 1);
    localparam int UW    = T_W + CW;
    localparam int PRW   = UW + NB_W;
    localparam int DIV_W = PRW - T_W;

    // configuration
    logic [2:0]                degree_reg;
    logic [7:0]                scount_reg;
    logic signed [COORD_W-1:0] mat_xx_reg, mat_xy_reg, mat_yx_reg, mat_yy_reg;
    logic signed [COORD_W-1:0] shift_x_reg, shift_y_reg;

    // control point memory
    logic signed [COORD_W-1:0] ctrl_x_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] ctrl_y_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] rdx_reg, rdy_reg;
    logic [CW-1:0]             count_reg;

    bce_state_t state_reg, state_next;

    logic [DW-1:0]   d_reg, j_reg, r_reg;
    logic [CW-1:0]   p_reg, slen_reg, sp_reg;
    logic [7:0]      s_reg;
    logic [T_W-1:0]  t_reg;
    logic [UW-1:0]   u_reg;
    logic            ab_reg;
    logic [PRW-1:0]  prod_reg;
    logic [NB_W-1:0] a_reg, saved_reg;
    logic [NB_W-1:0] nb_reg [MAX_DEGREE + 1];

    logic signed [CP_W-1:0]  cpx_reg, cpy_reg;
    logic signed [ACC_W-1:0] accx_reg, accy_reg;
    logic signed [PX_W-1:0]  px_reg, py_reg;
    logic signed [MP_W-1:0]  mxx_reg, mxy_reg, myx_reg, myy_reg;

    logic signed [COORD_W-1:0] res_x_reg, res_y_reg;
    status_t                   res_status_reg;
    logic                      m_valid_reg;
    bce_out_t                  m_data_reg;

    // divider hookup
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;

    // knot lookup and term operands
    logic [KIW-1:0] k_idx, hi_idx, lo_idx;
    logic [CW-1:0]  knot_hi, knot_lo, span;
    logic [UW-1:0]  right_dist, left_dist;
    logic [DW-1:0]  d_eff;
    logic           accept, is_eval, load_ok, last_term, last_row;

    function automatic logic [CW-1:0] knot_at(input logic [KIW-1:0] idx,
                                              input logic [DW-1:0]  dg,
                                              input logic [CW-1:0]  pc,
                                              input logic [CW-1:0]  sl);
        logic [CW-1:0] kv;
        if (idx <= KIW'(dg)) begin
            kv = '0;
        end else if (idx >= KIW'(pc)) begin
            kv = sl;
        end else begin
            kv = CW'(idx - KIW'(dg));
        end
        return kv;
    endfunction

    // round half up from Q.12 (Q4.12 matrix times coordinate) to coordinate scale, add translation, saturate to 16 bits
    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [MS_W-1:0] v,
                                                        input logic signed [COORD_W-1:0] sh);
        logic signed [MS_W-1:0] rb;
        logic signed [MT_W-1:0] tot;
        logic signed [COORD_W-1:0] o;
        rb  = v + (MS_W'(1) <<< (MAT_FRAC - 1));
        tot = MT_W'($signed(rb[MS_W-1:MAT_FRAC])) + MT_W'(sh);
        if (tot > MT_W'(32767)) begin
            o = 16'sh7FFF;
        end else if (tot < -MT_W'(32768)) begin
            o = 16'sh8000;
        end else begin
            o = tot[COORD_W-1:0];
        end
        return o;
    endfunction

    assign accept  = s_valid && s_ready;
    assign is_eval = (s_data.action == ACT_EVAL);
    assign load_ok = ({{(CW + 2){1'b0}}, s_data.point_index} < (CW + 8)'(MAX_POINTS));

    always_comb begin
        if (degree_reg == 3'd0) begin
            d_eff = DW'(1);
        end else if ({1'b0, degree_reg} > 4'(MAX_DEGREE)) begin
            d_eff = DW'(MAX_DEGREE);
        end else begin
            d_eff = DW'(degree_reg);
        end
    end

    assign k_idx      = KIW'(sp_reg) + KIW'(d_reg);
    assign hi_idx     = k_idx + KIW'(r_reg) + KIW'(1);
    assign lo_idx     = hi_idx - KIW'(j_reg);
    assign knot_hi    = knot_at(hi_idx, d_reg, p_reg, slen_reg);
    assign knot_lo    = knot_at(lo_idx, d_reg, p_reg, slen_reg);
    assign span       = knot_hi - knot_lo;
    assign right_dist = {knot_hi, {T_W{1'b0}}} - u_reg;
    assign left_dist  = u_reg - {knot_lo, {T_W{1'b0}}};
    assign last_term  = (r_reg == j_reg - DW'(1));
    assign last_row   = (j_reg == d_reg);

    assign div_start = (state_reg == ST_T_DIV) || (state_reg == ST_B_DIV);
    assign div_num   = (state_reg == ST_T_DIV)
                     ? DIV_W'({s_reg, {T_W{1'b0}}} - 24'(s_reg))
                     : prod_reg[PRW-1:T_W];
    assign div_den   = (state_reg == ST_T_DIV) ? scount_reg : DEN_W'(span);

    bce_div #(
        .NUM_W (DIV_W),
        .DEN_W (DEN_W),
        .STEP  (DIV_STEP)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && is_eval) begin
                    if (count_reg <= CW'(d_eff)) begin
                        state_next = ST_DONE;
                    end else if (s_data.sample_index > scount_reg) begin
                        state_next = ST_DONE;
                    end else if (scount_reg == 8'd0) begin
                        state_next = ST_U_MUL;
                    end else begin
                        state_next = ST_T_DIV;
                    end
                end
            end
            ST_T_DIV:  state_next = ST_T_WAIT;
            ST_T_WAIT: if (div_done) state_next = ST_U_MUL;
            ST_U_MUL:  state_next = ST_SPAN;
            ST_SPAN:   state_next = ST_B_PROD;
            ST_B_PROD: begin
                if (span == '0) begin
                    state_next = (last_term && last_row) ? ST_S_RD : ST_B_PROD;
                end else begin
                    state_next = ST_B_DIV;
                end
            end
            ST_B_DIV:  state_next = ST_B_WAIT;
            ST_B_WAIT: begin
                if (div_done) begin
                    if (!ab_reg) begin
                        state_next = ST_B_PROD;
                    end else begin
                        state_next = (last_term && last_row) ? ST_S_RD : ST_B_PROD;
                    end
                end
            end
            ST_S_RD:   state_next = ST_S_MUL;
            ST_S_MUL:  state_next = ST_S_ACC;
            ST_S_ACC:  state_next = (r_reg == d_reg) ? ST_X_RND : ST_S_RD;
            ST_X_RND:  state_next = ST_X_MUL;
            ST_X_MUL:  state_next = ST_X_SUM;
            ST_X_SUM:  state_next = ST_DONE;
            ST_DONE:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg  <= DEGREE_RST;
            scount_reg  <= SCOUNT_RST;
            mat_xx_reg  <= UNITY_Q12;
            mat_xy_reg  <= '0;
            mat_yx_reg  <= '0;
            mat_yy_reg  <= UNITY_Q12;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_DEGREE:       degree_reg  <= cfg_data[2:0];
                CFG_SAMPLE_COUNT: scount_reg  <= cfg_data[7:0];
                CFG_MAT_XX:       mat_xx_reg  <= cfg_data;
                CFG_MAT_XY:       mat_xy_reg  <= cfg_data;
                CFG_MAT_YX:       mat_yx_reg  <= cfg_data;
                CFG_MAT_YY:       mat_yy_reg  <= cfg_data;
                CFG_SHIFT_X:      shift_x_reg <= cfg_data;
                CFG_SHIFT_Y:      shift_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // point count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept && !is_eval && load_ok && s_data.last_point) begin
            count_reg <= CW'(s_data.point_index) + CW'(1);
        end
    end

    // control point memory, one write and one read port
    always_ff @(posedge aclk) begin
        if (accept && !is_eval && load_ok) begin
            ctrl_x_mem[AW'(s_data.point_index)] <= s_data.point_x;
            ctrl_y_mem[AW'(s_data.point_index)] <= s_data.point_y;
        end
        if (state_reg == ST_S_RD) begin
            rdx_reg <= ctrl_x_mem[AW'(sp_reg + CW'(r_reg))];
            rdy_reg <= ctrl_y_mem[AW'(sp_reg + CW'(r_reg))];
        end
    end

    // evaluation datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                d_reg    <= d_eff;
                p_reg    <= count_reg;
                slen_reg <= count_reg - CW'(d_eff);
                s_reg    <= s_data.sample_index;
                t_reg    <= '0;
                res_x_reg <= '0;
                res_y_reg <= '0;
                if (count_reg <= CW'(d_eff)) begin
                    res_status_reg <= STATUS_FEW_POINTS;
                end else begin
                    res_status_reg <= STATUS_RANGE;
                end
            end
            ST_T_WAIT: begin
                if (div_done) begin
                    t_reg <= div_quo[T_W-1:0];
                end
            end
            ST_U_MUL: begin
                u_reg <= UW'(t_reg) * UW'(slen_reg);
            end
            ST_SPAN: begin
                // u stays below slen, the clamp only guards the top span
                if (u_reg[UW-1:T_W] > slen_reg - CW'(1)) begin
                    sp_reg <= slen_reg - CW'(1);
                end else begin
                    sp_reg <= u_reg[UW-1:T_W];
                end
                nb_reg[0] <= NB_W'(1) << NB_FRAC;
                j_reg     <= DW'(1);
                r_reg     <= '0;
                saved_reg <= '0;
                ab_reg    <= 1'b0;
                accx_reg  <= '0;
                accy_reg  <= '0;
            end
            ST_B_PROD: begin
                prod_reg <= (ab_reg ? left_dist : right_dist) * nb_reg[r_reg];
                if (span == '0) begin
                    // empty knot span contributes nothing to either neighbor
                    nb_reg[r_reg] <= saved_reg;
                    if (last_term) begin
                        nb_reg[j_reg] <= '0;
                        saved_reg     <= '0;
                        r_reg         <= '0;
                        j_reg         <= j_reg + DW'(1);
                    end else begin
                        saved_reg <= '0;
                        r_reg     <= r_reg + DW'(1);
                    end
                end
            end
            ST_B_WAIT: begin
                if (div_done) begin
                    if (!ab_reg) begin
                        a_reg  <= div_quo[NB_W-1:0];
                        ab_reg <= 1'b1;
                    end else begin
                        ab_reg        <= 1'b0;
                        nb_reg[r_reg] <= saved_reg + a_reg;
                        if (last_term) begin
                            nb_reg[j_reg] <= div_quo[NB_W-1:0];
                            saved_reg     <= '0;
                            r_reg         <= '0;
                            j_reg         <= j_reg + DW'(1);
                        end else begin
                            saved_reg <= div_quo[NB_W-1:0];
                            r_reg     <= r_reg + DW'(1);
                        end
                    end
                end
            end
            ST_S_MUL: begin
                cpx_reg <= $signed({1'b0, nb_reg[r_reg]}) * rdx_reg;
                cpy_reg <= $signed({1'b0, nb_reg[r_reg]}) * rdy_reg;
            end
            ST_S_ACC: begin
                accx_reg <= accx_reg + ACC_W'(cpx_reg);
                accy_reg <= accy_reg + ACC_W'(cpy_reg);
                r_reg    <= r_reg + DW'(1);
            end
            ST_X_RND: begin
                px_reg <= $signed(PX_W'((accx_reg + (ACC_W'(1) <<< (NB_FRAC - 1)))
                                        >>> NB_FRAC));
                py_reg <= $signed(PX_W'((accy_reg + (ACC_W'(1) <<< (NB_FRAC - 1)))
                                        >>> NB_FRAC));
            end
            ST_X_MUL: begin
                mxx_reg <= mat_xx_reg * px_reg;
                mxy_reg <= mat_xy_reg * py_reg;
                myx_reg <= mat_yx_reg * px_reg;
                myy_reg <= mat_yy_reg * py_reg;
            end
            ST_X_SUM: begin
                res_x_reg      <= sat16(MS_W'(mxx_reg) + MS_W'(mxy_reg), shift_x_reg);
                res_y_reg      <= sat16(MS_W'(myx_reg) + MS_W'(myy_reg), shift_y_reg);
                res_status_reg <= STATUS_OK;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.curve_x <= res_x_reg;
            m_data_reg.curve_y <= res_y_reg;
            m_data_reg.status  <= res_status_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // control point reads stay inside the loaded points
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_S_RD) |-> (({1'b0, sp_reg} + (CW + 1)'(r_reg)) < {1'b0, p_reg}))
        else $error("control point read beyond point count");

    // basis triangle indices stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B_PROD) |-> (j_reg >= DW'(1) && j_reg <= d_reg && r_reg < j_reg))
        else $error("basis term index out of range");

    // a divider result only arrives while someone waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_T_WAIT || state_reg == ST_B_WAIT))
        else $error("divider result with no waiting step");

endmodule
